FILE: rtl/mmio_region_address_decoder_macros.svh
// assertion macros for the mmio region address decoder checker
// used by files that hold concurrent assertions; no other dependencies
`ifndef MMIO_REGION_ADDRESS_DECODER_MACROS_SVH
`define MMIO_REGION_ADDRESS_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MRAD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrad assertion failed");

// next-cycle implication, disabled while reset is low
`define MRAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrad assertion failed");

`endif

FILE: rtl/mrad_pkg.sv
// shared constants and types of the mmio region address decoder
// no dependencies; imported by every module of the block
package mrad_pkg;

  localparam int MaxRegions = 16;
  localparam int SlotW      = $clog2(MaxRegions);
  localparam int IdxW       = 4;
  localparam int AddrW      = 32;
  localparam int DataW      = 32;
  localparam int CapsW      = 4;
  localparam int TagW       = 8;
  localparam int FuncW      = 3;
  localparam int StatusW    = 3;

  localparam logic [FuncW-1:0] FuncMap    = 3'd0;
  localparam logic [FuncW-1:0] FuncRdByte = 3'd1;
  localparam logic [FuncW-1:0] FuncRdWord = 3'd2;
  localparam logic [FuncW-1:0] FuncWrByte = 3'd3;
  localparam logic [FuncW-1:0] FuncWrWord = 3'd4;

  localparam logic [StatusW-1:0] StOk     = 3'd0;
  localparam logic [StatusW-1:0] StBadMem = 3'd1;
  localparam logic [StatusW-1:0] StBadOp  = 3'd2;
  localparam logic [StatusW-1:0] StUsed   = 3'd3;
  localparam logic [StatusW-1:0] StFull   = 3'd4;

  localparam logic [AddrW-1:0] WordBytes = 32'd4;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] lim;
    logic [CapsW-1:0] caps;
    logic [TagW-1:0]  tag;
  } slot_t;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] addr;
    slot_t            data;
  } ram_wr_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdxW-1:0]    idx;
    logic [AddrW-1:0]   rel;
    logic [TagW-1:0]    tag;
    logic [DataW-1:0]   fwd;
  } res_t;

  typedef enum logic [2:0] {
    StateIdle = 3'b001,
    StateScan = 3'b010,
    StateOut  = 3'b100
  } state_e;

endpackage

FILE: rtl/mmio_region_address_decoder.sv
// mmio region address decoder: region table with map requests and access lookup
// Channels: one request channel (func_i, addr_i, new_end_i, new_caps_i,
// new_tag_i, write_data_i) under in_valid_i / in_stall_o, and one result
// channel (status_o, region_index_o, region_offset_o, device_tag_o, fwd_data_o)
// under out_valid_o / out_stall_i. Every request yields exactly one result.
// A request is taken when in_valid_i is high and in_stall_o is low; the
// block then holds in_stall_o high until the result has moved into the
// output register. Region data sits in a 16-entry table memory with a
// registered read port, read one slot per cycle; used bits are flip-flops.
// A map request scans the slots until one overlaps its range, else all 16
// slots; an access stops at the slot it hits, a miss scans all 16. An empty
// map range or an unknown func skips the scan. A new request is taken only
// after the last result has moved into the output register.
// Stall: a waiting result stays in the output register while a new request
// is taken; a finished result waits in the engine until the register frees.
// Reset clears all used bits, so no region is mapped; no clearing pass.
module mmio_region_address_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mrad_pkg::FuncW-1:0]    func_i,
  input  logic [mrad_pkg::AddrW-1:0]    addr_i,
  input  logic [mrad_pkg::AddrW-1:0]    new_end_i,
  input  logic [mrad_pkg::CapsW-1:0]    new_caps_i,
  input  logic [mrad_pkg::TagW-1:0]     new_tag_i,
  input  logic [mrad_pkg::DataW-1:0]    write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mrad_pkg::StatusW-1:0]  status_o,
  output logic [mrad_pkg::IdxW-1:0]     region_index_o,
  output logic [mrad_pkg::AddrW-1:0]    region_offset_o,
  output logic [mrad_pkg::TagW-1:0]     device_tag_o,
  output logic [mrad_pkg::DataW-1:0]    fwd_data_o
);
  import mrad_pkg::*;

  state_e                state_q, state_d;
  logic [SlotW-1:0]      cnt_q, cnt_d;
  logic [MaxRegions-1:0] used_q, used_d;
  logic                  free_found_q, free_found_d;
  logic [SlotW-1:0]      free_idx_q, free_idx_d;
  res_t                  res_q, res_d;
  res_t                  out_q;
  logic                  out_valid_q;

  logic [FuncW-1:0]      req_func_q;
  logic [AddrW-1:0]      req_addr_q;
  logic [AddrW-1:0]      req_end_q;
  logic [CapsW-1:0]      req_caps_q;
  logic [TagW-1:0]       req_tag_q;
  logic [DataW-1:0]      req_wdata_q;

  ram_wr_t               wr;
  logic [SlotW-1:0]      raddr;
  slot_t                 cur;

  logic                  accept;
  logic                  out_free;
  logic                  scan_last;
  logic                  cur_used;
  logic                  hit_overlap;
  logic                  hit_access;
  logic                  cap_ok;
  logic                  is_word;
  logic                  is_write;
  logic [AddrW-1:0]      span;
  logic [SlotW-1:0]      take_idx;
  logic                  have_free;

  mrad_slot_ram u_slot_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (cur)
  );

  assign in_stall_o = (state_q != StateIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign scan_last   = (cnt_q == SlotW'(MaxRegions - 1));
  assign cur_used    = used_q[cnt_q];
  assign hit_overlap = cur_used && (cur.start < req_end_q) && (req_addr_q < cur.lim);
  assign hit_access  = cur_used && (cur.start <= req_addr_q) && (req_addr_q < cur.lim);
  assign span        = cur.lim - req_addr_q;
  assign is_word     = (req_func_q == FuncRdWord) || (req_func_q == FuncWrWord);
  assign is_write    = (req_func_q == FuncWrByte) || (req_func_q == FuncWrWord);
  assign have_free   = free_found_q || !cur_used;
  assign take_idx    = free_found_q ? free_idx_q : cnt_q;

  always_comb begin
    case (req_func_q)
      FuncRdByte: cap_ok = cur.caps[0];
      FuncRdWord: cap_ok = cur.caps[1];
      FuncWrByte: cap_ok = cur.caps[2];
      FuncWrWord: cap_ok = cur.caps[3];
      default:    cap_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    used_d       = used_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    res_d        = res_q;
    raddr        = '0;
    wr.we        = 1'b0;
    wr.addr      = take_idx;
    wr.data      = '{start: req_addr_q, lim: req_end_q, caps: req_caps_q, tag: req_tag_q};

    unique case (state_q)
      StateIdle: begin
        if (accept) begin
          res_d        = '0;
          cnt_d        = '0;
          free_found_d = 1'b0;
          if (func_i == FuncMap && new_end_i <= addr_i) begin
            res_d.status = StBadMem;
            state_d      = StateOut;
          end else if (func_i > FuncWrWord) begin
            res_d.status = StBadOp;
            state_d      = StateOut;
          end else begin
            state_d = StateScan;
          end
        end
      end
      StateScan: begin
        // read of the next slot goes out while the current one is checked
        raddr = scan_last ? '0 : cnt_q + SlotW'(1);
        cnt_d = cnt_q + SlotW'(1);
        if (req_func_q == FuncMap) begin
          if (hit_overlap) begin
            res_d.status = StUsed;
            state_d      = StateOut;
          end else begin
            if (!cur_used && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = cnt_q;
            end
            if (scan_last) begin
              state_d = StateOut;
              if (have_free) begin
                wr.we            = 1'b1;
                used_d[take_idx] = 1'b1;
                res_d.status     = StOk;
                res_d.idx        = IdxW'(take_idx);
                res_d.tag        = req_tag_q;
              end else begin
                res_d.status = StFull;
              end
            end
          end
        end else if (hit_access) begin
          state_d   = StateOut;
          res_d.idx = IdxW'(cnt_q);
          res_d.tag = cur.tag;
          if (!cap_ok) begin
            res_d.status = StBadOp;
          end else if (is_word && span < WordBytes) begin
            res_d.status = StBadMem;
          end else begin
            res_d.status = StOk;
            res_d.rel    = req_addr_q - cur.start;
            res_d.fwd    = is_write ? req_wdata_q : '0;
          end
        end else if (scan_last) begin
          res_d.status = StBadMem;
          state_d      = StateOut;
        end
      end
      StateOut: begin
        if (out_free) begin
          state_d = StateIdle;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StateIdle;
      cnt_q        <= '0;
      used_q       <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      used_q       <= used_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      if (state_q == StateOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      req_func_q  <= func_i;
      req_addr_q  <= addr_i;
      req_end_q   <= new_end_i;
      req_caps_q  <= new_caps_i;
      req_tag_q   <= new_tag_i;
      req_wdata_q <= write_data_i;
    end
    if (state_q == StateOut && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign region_index_o  = out_q.idx;
  assign region_offset_o = out_q.rel;
  assign device_tag_o    = out_q.tag;
  assign fwd_data_o      = out_q.fwd;

endmodule

FILE: rtl/mrad_slot_ram.sv
// region table memory: one write port, one registered read port
// depends on mrad_pkg for the entry and write port types
module mrad_slot_ram (
  input  logic                      clk_i,
  input  mrad_pkg::ram_wr_t         wr_i,
  input  logic [mrad_pkg::SlotW-1:0] raddr_i,
  output mrad_pkg::slot_t           rdata_o
);
  import mrad_pkg::*;

  slot_t mem [MaxRegions];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mrad_checker.sv
// port-level checker for the mmio region address decoder, bound to the top level
// depends on mrad_pkg and the assertion macro header
`include "mmio_region_address_decoder_macros.svh"

module mrad_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [mrad_pkg::StatusW-1:0] status_o,
  input logic [mrad_pkg::DataW-1:0]   fwd_data_o
);
  import mrad_pkg::*;

  // only one request is in flight at a time
  `MRAD_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a stalled result holds
  `MRAD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(fwd_data_o))

  // write data only passes on a successful access
  `MRAD_ASSERT_NOW(a_fwd_only_ok, clk_i, rst_ni, out_valid_o && status_o != StOk, fwd_data_o == '0)

endmodule

bind mmio_region_address_decoder mrad_checker u_mrad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .fwd_data_o  (fwd_data_o)
);
